// File: rtl/tfdc_pkg.sv
// ============================================================================
// tfdc_pkg
// Shared types and constants for the typed field to binary64 converter.
// ============================================================================
package tfdc_pkg;

    typedef enum logic [2:0] {
        TYPE_U8  = 3'd0,
        TYPE_I8  = 3'd1,
        TYPE_U16 = 3'd2,
        TYPE_I16 = 3'd3,
        TYPE_U32 = 3'd4,
        TYPE_I32 = 3'd5,
        TYPE_F32 = 3'd6,
        TYPE_F64 = 3'd7
    } type_code_t;

    localparam int unsigned EXP_BIAS = 1023;

    typedef struct packed {
        logic [2:0]  type_code;
        logic [63:0] value_bytes;
    } in_item_t;

    typedef struct packed {
        logic [63:0] double_bits;
    } out_item_t;

endpackage

// File: rtl/tfdc_stream_if.sv
// ============================================================================
// tfdc_stream_if
// Valid/ready channel that carries one item of a given payload type.
// ============================================================================
interface tfdc_stream_if #(parameter type payload_t = logic [63:0]);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/tfdc_convert.sv
// ============================================================================
// tfdc_convert
// Combinational conversion of one typed field into a binary64 bit pattern.
// ============================================================================
module tfdc_convert
    import tfdc_pkg::*;
(
    input  logic [2:0]  type_code,
    input  logic [63:0] value_bytes,
    output logic [63:0] double_bits
);

    logic        neg;
    logic [31:0] mag;
    logic [4:0]  pos;
    logic        found;
    logic [63:0] int_bits;
    logic [63:0] f32_bits;
    logic [31:0] w;
    logic [22:0] frac32;
    logic [7:0]  exp32;
    logic [52:0] shifted;
    logic [10:0] exp_int;
    logic [10:0] exp_sub;

    assign w      = value_bytes[31:0];
    assign frac32 = w[22:0];
    assign exp32  = w[30:23];

    always_comb
    begin
        neg = 1'b0;
        mag = 32'd0;
        case (type_code_t'(type_code))
            TYPE_U8:  mag = {24'd0, value_bytes[7:0]};
            TYPE_I8:
            begin
                neg = value_bytes[7];
                mag = {24'd0, neg ? (8'd0 - value_bytes[7:0]) : value_bytes[7:0]};
                if (neg && value_bytes[7:0] == 8'h80)
                    mag = 32'd128;
            end
            TYPE_U16: mag = {16'd0, value_bytes[15:0]};
            TYPE_I16:
            begin
                neg = value_bytes[15];
                mag = {16'd0, neg ? (16'd0 - value_bytes[15:0]) : value_bytes[15:0]};
                if (neg && value_bytes[15:0] == 16'h8000)
                    mag = 32'd32768;
            end
            TYPE_U32: mag = value_bytes[31:0];
            TYPE_F32: mag = {9'd0, frac32};
            default:
            begin
                neg = value_bytes[31];
                mag = neg ? (32'd0 - value_bytes[31:0]) : value_bytes[31:0];
            end
        endcase
    end

    always_comb
    begin
        pos   = 5'd0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!found && mag[i])
            begin
                pos   = 5'(i);
                found = 1'b1;
            end
        end
    end

    assign shifted  = {21'd0, mag} << (6'd52 - {1'b0, pos});
    assign exp_int  = 11'(EXP_BIAS) + {6'd0, pos};
    assign exp_sub  = exp_int - 11'd149;
    assign int_bits = found ? {neg, exp_int, shifted[51:0]} : 64'd0;

    always_comb
    begin
        if (exp32 == 8'hFF)
            f32_bits = {w[31], 11'h7FF, frac32, 29'd0};
        else if (exp32 == 8'd0)
            f32_bits = found ? {w[31], exp_sub, shifted[51:0]} : {w[31], 63'd0};
        else
            f32_bits = {w[31], {3'd0, exp32} + 11'd896, frac32, 29'd0};
    end

    always_comb
    begin
        case (type_code_t'(type_code))
            TYPE_F32: double_bits = f32_bits;
            TYPE_F64: double_bits = value_bytes;
            default:  double_bits = int_bits;
        endcase
    end

endmodule

// File: rtl/typed_field_to_double_converter_core.sv
// ============================================================================
// typed_field_to_double_converter_core
// Converts a typed record field into its IEEE-754 binary64 encoding.
// ============================================================================
// The in channel carries a type code and eight little-endian record bytes.
// The out channel returns one binary64 bit pattern per item, in order.
// An accepted item is held in an input register; the conversion runs in
// combinational logic between the input register and a result register.
// Throughput is one item per cycle while the receiver does not stall,
// set by the single conversion stage between the two registers.
// When the receiver stalls, the result register holds and the input register
// keeps its item; a new item is taken whenever the downstream stage will move
// in the same cycle, so the pipeline holds at most two items.
// Reset clears both valid flags; the block accepts items right after reset.
module typed_field_to_double_converter_core
    import tfdc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tfdc_stream_if.sink   in_ch,
    tfdc_stream_if.source out_ch
);

    logic        in_valid_reg;
    logic [2:0]  type_reg;
    logic [63:0] bytes_reg;
    logic        out_valid_reg;
    logic [63:0] result_reg;
    logic [63:0] result_next;
    logic        out_ready_slot;
    logic        in_ready;

    tfdc_convert u_convert (
        .type_code   (type_reg),
        .value_bytes (bytes_reg),
        .double_bits (result_next)
    );

    assign out_ready_slot = !out_valid_reg || out_ch.ready;
    assign in_ready       = !in_valid_reg || out_ready_slot;

    assign in_ch.ready    = in_ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = '{double_bits: result_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_ch.valid;
            if (out_ready_slot)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ch.valid)
        begin
            type_reg  <= in_ch.payload.type_code;
            bytes_reg <= in_ch.payload.value_bytes;
        end
        if (out_ready_slot && in_valid_reg)
            result_reg <= result_next;
    end

endmodule

// File: rtl/tfdc_checker.sv
// ============================================================================
// tfdc_checker
// Port-level checks for the typed field to binary64 converter.
// ============================================================================
module tfdc_checker
    import tfdc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_payload
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("Stalled result changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("Accepted item produced no result in time.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("Input stalled with an empty output.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("Result appeared without an item.");

endmodule

bind typed_field_to_double_converter_core tfdc_checker u_tfdc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);
